// File: rtl/core/rbcd_pkg.sv
`default_nettype none

package rbcd_pkg;

    // Built slot count used when the top level is not overridden.
    localparam int DEF_SLOTS = 64;

    // Milliseconds per second for the stall limit.
    localparam int MS_PER_SEC = 1000;

    // Operation codes of the input transaction.
    localparam logic [2:0] OP_CLAIM    = 3'd0;
    localparam logic [2:0] OP_COMPLETE = 3'd1;
    localparam logic [2:0] OP_FAIL     = 3'd2;
    localparam logic [2:0] OP_CHECK    = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_STOP     = 3'd5;

    // Result codes of the output transaction.
    localparam logic [2:0] RC_GRANT = 3'd0;
    localparam logic [2:0] RC_NONE  = 3'd1;
    localparam logic [2:0] RC_STALE = 3'd2;
    localparam logic [2:0] RC_ACC   = 3'd3;
    localparam logic [2:0] RC_STOP  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START   = 3'd0;
    localparam logic [2:0] CFG_END     = 3'd1;
    localparam logic [2:0] CFG_CHUNK   = 3'd2;
    localparam logic [2:0] CFG_SLOTS   = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       div_total;
        logic       div_id;
        logic       save_total;
        logic       idx_clr;
        logic       idx_inc;
        logic       mul_id;
        logic       mul_first;
        logic       claim_commit;
        logic       adv_mul;
        logic       adv_commit;
        logic       complete_commit;
        logic       fail_commit;
        logic       stall_rd;
        logic       stall_chk;
        logic       busy_acc;
        logic       tick;
        logic       halt;
        logic       out_load;
        logic [2:0] code;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       div_done;
        logic       halted;
        logic [2:0] op;
        logic       id_match;
        logic       is_last;
        logic       cur_free;
        logic       cur_busy;
        logic       cur_done;
        logic       adv_ok;
        logic       first_past;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/core/rbcd_div.sv
`default_nettype none

module rbcd_div
    import rbcd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [32:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_done,
    output logic [32:0]      o_quo,
    output logic [15:0]      o_rem
);

    localparam int NBITS = 33;

    logic        r_run;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] rem_sh;
    logic [16:0] diff;

    // One quotient bit per cycle, restoring form.
    assign rem_sh = {r_rem, r_quo[32]};
    assign diff   = rem_sh - {1'b0, r_den};

    // Control state of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == 6'd1);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 6'(NBITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_run) begin
            if (!diff[16]) begin
                r_rem <= diff[15:0];
                r_quo <= {r_quo[31:0], 1'b1};
            end else begin
                r_rem <= rem_sh[15:0];
                r_quo <= {r_quo[31:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: rtl/core/rbcd_dp.sv
`default_nettype none

module rbcd_dp
    import rbcd_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_chunk_number,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    output logic [2:0]       o_result_code,
    output logic [31:0]      o_granted_chunk,
    output logic [31:0]      o_first_block,
    output logic [31:0]      o_last_block,
    output logic [31:0]      o_completed_total,
    output logic [6:0]       o_busy_slots,
    output logic [31:0]      o_round_number,
    output logic             o_all_done
);

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int IDW = 32 + CW;
    localparam int FW  = IDW + 17;
    localparam int PW  = 33 + CW;
    localparam int LW  = 26;

    // Configuration registers.
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [15:0] r_chunk;
    logic [6:0]  r_siu;
    logic [15:0] r_tmo;

    // Dispatcher state.
    logic [SLOTS-1:0] r_busy_v;
    logic [SLOTS-1:0] r_done_v;
    logic [47:0]      r_stamp_mem [SLOTS];
    logic [47:0]      r_stamp_q;
    logic [31:0]      r_round;
    logic [31:0]      r_done_cnt;
    logic [47:0]      r_now;
    logic             r_halted;
    logic [IW-1:0]    r_idx;
    logic [CW-1:0]    r_bcnt;

    // Per-transaction working registers.
    logic [2:0]     r_op;
    logic [31:0]    r_id_in;
    logic [31:0]    r_total;
    logic [IDW-1:0] r_id;
    logic [FW-1:0]  r_first;
    logic [PW-1:0]  r_prod;
    logic [LW-1:0]  r_limit;
    logic [31:0]    r_g_chunk;
    logic [31:0]    r_g_first;
    logic [31:0]    r_g_last;

    // Output registers.
    logic [2:0]  r_o_code;
    logic [31:0] r_o_chunk;
    logic [31:0] r_o_first;
    logic [31:0] r_o_last;
    logic [31:0] r_o_done;
    logic [6:0]  r_o_busy;
    logic [31:0] r_o_round;
    logic        r_o_all;

    logic [8:0]    siu9;
    logic [8:0]    n9;
    logic [CW-1:0] n_used;
    logic [15:0]   cs_eff;
    logic [32:0]   total_num;
    logic          div_start;
    logic [32:0]   div_num;
    logic [15:0]   div_den;
    logic          div_done;
    logic [32:0]   div_quo;
    logic [15:0]   div_rem;
    logic [IW-1:0] slot_s;
    logic [32:0]   last33;
    logic [31:0]   last_clip;
    logic [47:0]   elapsed;
    logic          stall_hit;

    // Effective slot count and chunk size.
    assign siu9   = {2'b00, r_siu};
    assign n9     = (siu9 == 9'd0) ? 9'd1 : ((siu9 > 9'(SLOTS)) ? 9'(SLOTS) : siu9);
    assign n_used = CW'(n9);
    assign cs_eff = (r_chunk == 16'd0) ? 16'd1 : r_chunk;

    // Divider operands: chunk total or chunk id over the slot count.
    assign total_num = (r_end < r_start) ? 33'd0 :
                       ({1'b0, r_end} - {1'b0, r_start} + {17'd0, cs_eff});
    assign div_start = i_cmd.div_total | i_cmd.div_id;
    assign div_num   = i_cmd.div_id ? {1'b0, r_id_in} : total_num;
    assign div_den   = i_cmd.div_id ? 16'(n_used) : cs_eff;

    rbcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign slot_s = div_rem[IW-1:0];

    // Last height of a grant, clipped to the end of the range.
    assign last33    = {1'b0, r_first[31:0]} + 33'(cs_eff) - 33'd1;
    assign last_clip = (last33 > {1'b0, r_end}) ? r_end : last33[31:0];

    // Stall test on the stamp read back for the current slot.
    assign elapsed   = r_now - r_stamp_q;
    assign stall_hit = elapsed > 48'(r_limit);

    // Status toward the controller.
    always_comb begin
        o_sts.div_done   = div_done;
        o_sts.halted     = r_halted;
        o_sts.op         = r_op;
        o_sts.id_match   = (div_quo == {1'b0, r_round});
        o_sts.is_last    = (CW'(r_idx) == (n_used - CW'(1)));
        o_sts.cur_free   = !r_busy_v[r_idx] && !r_done_v[r_idx];
        o_sts.cur_busy   = r_busy_v[r_idx];
        o_sts.cur_done   = r_done_v[r_idx];
        o_sts.adv_ok     = (r_prod < PW'(r_total));
        o_sts.first_past = (r_first > FW'(r_end));
    end

    // Configuration writes and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start    <= '0;
            r_end      <= '0;
            r_chunk    <= 16'd1;
            r_siu      <= 7'd1;
            r_tmo      <= '0;
            r_busy_v   <= '0;
            r_done_v   <= '0;
            r_round    <= '0;
            r_done_cnt <= '0;
            r_now      <= 48'd1;
            r_halted   <= 1'b0;
            r_idx      <= '0;
            r_bcnt     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_START:   r_start <= i_cfg_data;
                    CFG_END:     r_end   <= i_cfg_data;
                    CFG_CHUNK:   r_chunk <= i_cfg_data[15:0];
                    CFG_SLOTS:   r_siu   <= i_cfg_data[6:0];
                    CFG_TIMEOUT: r_tmo   <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end

            // Scan index and busy count.
            if (i_cmd.idx_clr) begin
                r_idx  <= '0;
                r_bcnt <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.busy_acc) begin
                r_bcnt <= r_bcnt + CW'(r_busy_v[r_idx]);
                if (!o_sts.is_last) begin
                    r_idx <= r_idx + IW'(1);
                end
            end

            // Slot flag updates.
            if (i_cmd.claim_commit) begin
                if (o_sts.first_past) begin
                    r_done_v[r_idx] <= 1'b1;
                end else begin
                    r_busy_v[r_idx] <= 1'b1;
                end
            end
            if (i_cmd.complete_commit) begin
                r_done_v[slot_s] <= 1'b1;
                r_busy_v[slot_s] <= 1'b0;
                if (r_done_cnt != 32'hFFFF_FFFF) begin
                    r_done_cnt <= r_done_cnt + 32'd1;
                end
            end
            if (i_cmd.fail_commit) begin
                r_busy_v[slot_s] <= 1'b0;
            end
            if (i_cmd.stall_chk && r_busy_v[r_idx] && stall_hit) begin
                r_busy_v[r_idx] <= 1'b0;
            end

            // Round advance frees every slot in use.
            if (i_cmd.adv_commit) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (CW'(i) < n_used) begin
                        r_busy_v[i] <= 1'b0;
                        r_done_v[i] <= 1'b0;
                    end
                end
                r_round <= r_round + 32'd1;
            end

            if (i_cmd.tick && (r_now != 48'hFFFF_FFFF_FFFF)) begin
                r_now <= r_now + 48'd1;
            end
            if (i_cmd.halt) begin
                r_halted <= 1'b1;
            end
        end
    end

    // Stamp memory, one entry per slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim_commit) begin
            r_stamp_mem[r_idx] <= r_now;
        end
        if (i_cmd.stall_rd) begin
            r_stamp_q <= r_stamp_mem[r_idx];
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_operation;
            r_id_in   <= i_chunk_number;
            r_limit   <= LW'(r_tmo) * LW'(MS_PER_SEC);
            r_g_chunk <= '0;
            r_g_first <= '0;
            r_g_last  <= '0;
        end
        if (i_cmd.save_total) begin
            r_total <= div_quo[32] ? 32'hFFFF_FFFF : div_quo[31:0];
        end
        if (i_cmd.mul_id) begin
            r_id <= IDW'(r_round) * IDW'(n_used) + IDW'(r_idx);
        end
        if (i_cmd.mul_first) begin
            r_first <= FW'(r_start) + FW'(r_id) * FW'(cs_eff);
        end
        if (i_cmd.adv_mul) begin
            r_prod <= PW'({1'b0, r_round} + 33'd1) * PW'(n_used);
        end
        if (i_cmd.claim_commit && !o_sts.first_past) begin
            r_g_chunk <= r_id[31:0];
            r_g_first <= r_first[31:0];
            r_g_last  <= last_clip;
        end
    end

    // Output register loaded when the result is handed over.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_code  <= i_cmd.code;
            r_o_chunk <= r_g_chunk;
            r_o_first <= r_g_first;
            r_o_last  <= r_g_last;
            r_o_done  <= r_done_cnt;
            r_o_busy  <= 7'(r_bcnt);
            r_o_round <= r_round;
            r_o_all   <= (r_done_cnt >= r_total);
        end
    end

    assign o_result_code     = r_o_code;
    assign o_granted_chunk   = r_o_chunk;
    assign o_first_block     = r_o_first;
    assign o_last_block      = r_o_last;
    assign o_completed_total = r_o_done;
    assign o_busy_slots      = r_o_busy;
    assign o_round_number    = r_o_round;
    assign o_all_done        = r_o_all;

    // A slot is never busy and completed at once.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy_v & r_done_v) == '0)
        else $error("slot both busy and completed");

    // A claim only commits on a free slot.
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim_commit |-> (!r_busy_v[r_idx] && !r_done_v[r_idx]))
        else $error("claim on a slot that is not free");

    // The busy count never exceeds the slots in use.
    a_bcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_bcnt <= n_used))
        else $error("busy count above slots in use");

endmodule

`default_nettype wire

// File: rtl/core/rbcd_ctrl.sv
`default_nettype none

module rbcd_ctrl
    import rbcd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_DIVT = 12'b0000_0000_0010,
        S_DISP = 12'b0000_0000_0100,
        S_SCAN = 12'b0000_0000_1000,
        S_CMUL = 12'b0000_0001_0000,
        S_CFIN = 12'b0000_0010_0000,
        S_ACMP = 12'b0000_0100_0000,
        S_DIVI = 12'b0000_1000_0000,
        S_SRD  = 12'b0001_0000_0000,
        S_SCHK = 12'b0010_0000_0000,
        S_CNT  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic       r_claim_mode, n_claim_mode;
    logic       r_seen_busy, n_seen_busy;
    logic [2:0] r_code, n_code;
    logic       r_out_valid, n_out_valid;
    t_dp_cmd    cmd;

    // Sequencer: dispatch on the operation, then scan, count and hand over.
    always_comb begin
        n_state      = r_state;
        n_claim_mode = r_claim_mode;
        n_seen_busy  = r_seen_busy;
        n_code       = r_code;
        n_out_valid  = r_out_valid && !i_out_ready;
        cmd          = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture   = 1'b1;
                    cmd.div_total = 1'b1;
                    n_state       = S_DIVT;
                end
            end
            S_DIVT: begin
                if (i_sts.div_done) begin
                    cmd.save_total = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                cmd.idx_clr = 1'b1;
                case (i_sts.op)
                    OP_CLAIM: begin
                        if (i_sts.halted) begin
                            n_code  = RC_STOP;
                            n_state = S_CNT;
                        end else begin
                            n_claim_mode = 1'b1;
                            n_seen_busy  = 1'b0;
                            n_state      = S_SCAN;
                        end
                    end
                    OP_COMPLETE, OP_FAIL: begin
                        cmd.div_id = 1'b1;
                        n_state    = S_DIVI;
                    end
                    OP_CHECK: begin
                        if (i_sts.halted) begin
                            n_code  = RC_STOP;
                            n_state = S_CNT;
                        end else begin
                            n_code  = RC_ACC;
                            n_state = S_SRD;
                        end
                    end
                    OP_TICK: begin
                        cmd.tick = 1'b1;
                        n_code   = RC_ACC;
                        n_state  = S_CNT;
                    end
                    OP_STOP: begin
                        cmd.halt = 1'b1;
                        n_code   = RC_STOP;
                        n_state  = S_CNT;
                    end
                    default: begin
                        n_code  = RC_NONE;
                        n_state = S_CNT;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_claim_mode) begin
                    // Claim: stop at the lowest free slot.
                    if (i_sts.cur_free) begin
                        cmd.mul_id = 1'b1;
                        n_state    = S_CMUL;
                    end else if (i_sts.is_last) begin
                        if (r_seen_busy || i_sts.cur_busy) begin
                            n_code      = RC_NONE;
                            cmd.idx_clr = 1'b1;
                            n_state     = S_CNT;
                        end else begin
                            cmd.adv_mul = 1'b1;
                            n_state     = S_ACMP;
                        end
                    end else begin
                        n_seen_busy = r_seen_busy || i_sts.cur_busy;
                        cmd.idx_inc = 1'b1;
                    end
                end else begin
                    // After a completion: advance only if every slot is done.
                    if (!i_sts.cur_done) begin
                        cmd.idx_clr = 1'b1;
                        n_state     = S_CNT;
                    end else if (i_sts.is_last) begin
                        cmd.adv_mul = 1'b1;
                        n_state     = S_ACMP;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_CMUL: begin
                cmd.mul_first = 1'b1;
                n_state       = S_CFIN;
            end
            S_CFIN: begin
                cmd.claim_commit = 1'b1;
                cmd.idx_clr      = 1'b1;
                n_code           = i_sts.first_past ? RC_NONE : RC_GRANT;
                n_state          = S_CNT;
            end
            S_ACMP: begin
                cmd.idx_clr = 1'b1;
                if (i_sts.adv_ok) begin
                    cmd.adv_commit = 1'b1;
                end
                if (r_claim_mode && i_sts.adv_ok) begin
                    n_seen_busy = 1'b0;
                    n_state     = S_SCAN;
                end else begin
                    if (r_claim_mode) begin
                        n_code = RC_NONE;
                    end
                    n_state = S_CNT;
                end
            end
            S_DIVI: begin
                if (i_sts.div_done) begin
                    cmd.idx_clr = 1'b1;
                    if (!i_sts.id_match) begin
                        n_code  = RC_STALE;
                        n_state = S_CNT;
                    end else if (i_sts.op == OP_COMPLETE) begin
                        cmd.complete_commit = 1'b1;
                        n_code              = RC_ACC;
                        n_claim_mode        = 1'b0;
                        n_state             = S_SCAN;
                    end else begin
                        cmd.fail_commit = 1'b1;
                        n_code          = RC_ACC;
                        n_state         = S_CNT;
                    end
                end
            end
            S_SRD: begin
                cmd.stall_rd = 1'b1;
                n_state      = S_SCHK;
            end
            S_SCHK: begin
                cmd.stall_chk = 1'b1;
                if (i_sts.is_last) begin
                    cmd.idx_clr = 1'b1;
                    n_state     = S_CNT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SRD;
                end
            end
            S_CNT: begin
                cmd.busy_acc = 1'b1;
                if (i_sts.is_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        cmd.code = r_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_claim_mode <= 1'b0;
            r_seen_busy  <= 1'b0;
            r_code       <= RC_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_claim_mode <= n_claim_mode;
            r_seen_busy  <= n_seen_busy;
            r_code       <= n_code;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // An accepted transaction starts the chunk total division.
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DIVT))
        else $error("accepted transaction did not start division");

    // A result is only loaded into a free or draining output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending output");

    // A loaded result is presented in the next cycle.
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: rtl/core/round_based_chunk_dispatcher_core.sv
// Round-based chunk dispatcher.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per
// operation: claim, complete, fail, timeout check, millisecond tick or stop,
// with a chunk id for complete and fail. Every input transaction produces
// exactly one result transaction on the output channel (o_out_valid /
// i_out_ready). Configuration writes use their own channel, which is always
// ready; the user must issue them only while the block is idle, unenforced.
// One transaction is worked on at a time. Each starts with a division in the
// shared serial divider for the chunk total, then counts busy slots at one
// slot per cycle over the n slots in use. Claims add a scan of the slots
// and the grant arithmetic, timeout checks add a stamp memory read and test
// per slot, completes add a second division of the chunk id by n plus a
// scan, and fails add the same division of the chunk id without a scan.
// The finished result sits in an output register; a stalled receiver holds
// it while the next transaction is already accepted and computed, which
// then waits for the register to drain.
// Reset clears all slots to free, the counters, the stop flag and the
// configuration to its defaults; no clearing pass is needed.
`default_nettype none

module round_based_chunk_dispatcher_core
    import rbcd_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_chunk_number,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_result_code,
    output logic [31:0]      o_granted_chunk,
    output logic [31:0]      o_first_block,
    output logic [31:0]      o_last_block,
    output logic [31:0]      o_completed_total,
    output logic [6:0]       o_busy_slots,
    output logic [31:0]      o_round_number,
    output logic             o_all_done
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Configuration is taken in any cycle.
    assign o_cfg_ready = 1'b1;

    rbcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rbcd_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_operation),
        .i_chunk_number    (i_chunk_number),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_result_code     (o_result_code),
        .o_granted_chunk   (o_granted_chunk),
        .o_first_block     (o_first_block),
        .o_last_block      (o_last_block),
        .o_completed_total (o_completed_total),
        .o_busy_slots      (o_busy_slots),
        .o_round_number    (o_round_number),
        .o_all_done        (o_all_done)
    );

endmodule

`default_nettype wire

// File: tb/round_based_chunk_dispatcher_core_tb.sv
`default_nettype none

module round_based_chunk_dispatcher_core_tb;
    import rbcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = DEF_SLOTS;
    localparam int DRAIN_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {SL_FREE, SL_BUSY, SL_DONE} t_slot_state;

    typedef struct {
        logic [2:0]  code;
        logic [31:0] chunk;
        logic [31:0] first;
        logic [31:0] last;
        logic [31:0] done;
        logic [6:0]  busy;
        logic [31:0] rnd;
        logic        alld;
    } t_dispatch_result;

    typedef struct {
        logic [2:0]       op;
        logic [31:0]      id;
        bit               typed;
        t_dispatch_result res;
    } t_request_row;

    // Clock, reset and block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_START;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_operation = OP_TICK;
    logic [31:0] i_chunk_number = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_result_code;
    logic [31:0] o_granted_chunk;
    logic [31:0] o_first_block;
    logic [31:0] o_last_block;
    logic [31:0] o_completed_total;
    logic [6:0]  o_busy_slots;
    logic [31:0] o_round_number;
    logic        o_all_done;

    always #1 i_clk = ~i_clk;

    round_based_chunk_dispatcher_core dut (.*);

    // Dispatcher mirror: configuration and slot table.
    logic [31:0]     cfg_start = 0, cfg_end = 0;
    logic [15:0]     cfg_chunk = 1, cfg_timeout = 0;
    logic [6:0]      cfg_slots = 1;
    t_slot_state     slot_st[NSLOT];
    longint unsigned slot_ts[NSLOT];
    logic [31:0]     cur_round = 0, done_cnt = 0;
    longint unsigned now_ms = 1;
    bit              stopped = 0;

    t_dispatch_result pending_results[$];
    int     errors = 0;
    int     idle_pct = 13;
    bit     in_hi = 0;
    longint cycles = 0;

    function automatic int unsigned slots_n();
        if (cfg_slots == 0) return 1;
        if (cfg_slots > NSLOT) return NSLOT;
        return cfg_slots;
    endfunction

    function automatic longint unsigned blk_len();
        return (cfg_chunk == 0) ? 1 : cfg_chunk;
    endfunction

    function automatic longint unsigned chunk_total();
        longint unsigned t;
        if (cfg_end < cfg_start) return 0;
        t = (longint'(cfg_end) - cfg_start + blk_len()) / blk_len();
        return (t > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t;
    endfunction

    // Move to the next round once every slot in use is completed.
    function automatic void try_advance();
        int unsigned n;
        longint unsigned nxt;
        n = slots_n();
        nxt = longint'(cur_round) + 1;
        for (int i = 0; i < n; i++)
            if (slot_st[i] != SL_DONE) return;
        if (nxt * n >= chunk_total()) return;
        for (int i = 0; i < n; i++) begin
            slot_st[i] = SL_FREE;
            slot_ts[i] = 0;
        end
        cur_round = nxt[31:0];
    endfunction

    // Claim the lowest free slot, retrying once after a round advance.
    function automatic logic [2:0] claim_slot(ref t_dispatch_result r);
        int unsigned n;
        logic [31:0] prev_round;
        longint unsigned id, first, last;
        bit all_complete;
        n = slots_n();
        for (int pass = 0; pass < 2; pass++) begin
            prev_round = cur_round;
            for (int i = 0; i < n; i++) begin
                if (slot_st[i] == SL_FREE) begin
                    id = longint'(cur_round) * n + i;
                    first = longint'(cfg_start) + id * blk_len();
                    slot_st[i] = SL_BUSY;
                    slot_ts[i] = now_ms;
                    if (first > cfg_end) begin
                        slot_st[i] = SL_DONE;
                        return RC_NONE;
                    end
                    last = first + blk_len() - 1;
                    if (last > cfg_end) last = cfg_end;
                    r.chunk = id[31:0];
                    r.first = first[31:0];
                    r.last = last[31:0];
                    return RC_GRANT;
                end
            end
            all_complete = 1;
            for (int i = 0; i < n; i++)
                if (slot_st[i] != SL_DONE) all_complete = 0;
            if (!all_complete) return RC_NONE;
            try_advance();
            if (cur_round == prev_round) return RC_NONE;
        end
        return RC_NONE;
    endfunction

    // Free in-progress slots whose stamp is older than the stall limit.
    function automatic void release_stalled();
        longint unsigned lim;
        lim = longint'(cfg_timeout) * MS_PER_SEC;
        for (int i = 0; i < slots_n(); i++)
            if (slot_st[i] == SL_BUSY && slot_ts[i] > 0 &&
                ((now_ms - slot_ts[i]) & MAX48) > lim)
                slot_st[i] = SL_FREE;
    endfunction

    function automatic t_dispatch_result dispatch_outcome(logic [2:0] op, logic [31:0] id);
        t_dispatch_result r;
        int unsigned n, s, busy;
        r = '{default: '0};
        n = slots_n();
        busy = 0;
        case (op)
            OP_CLAIM: r.code = stopped ? RC_STOP : claim_slot(r);
            OP_COMPLETE, OP_FAIL: begin
                if (id / n != cur_round) begin
                    r.code = RC_STALE;
                end else begin
                    s = id % n;
                    r.code = RC_ACC;
                    if (op == OP_COMPLETE) begin
                        slot_st[s] = SL_DONE;
                        if (done_cnt != 32'hFFFF_FFFF) done_cnt++;
                        try_advance();
                    end else if (slot_st[s] == SL_BUSY) begin
                        slot_st[s] = SL_FREE;
                    end
                end
            end
            OP_CHECK: begin
                if (stopped) begin
                    r.code = RC_STOP;
                end else begin
                    release_stalled();
                    r.code = RC_ACC;
                end
            end
            OP_TICK: begin
                if (now_ms < MAX48) now_ms++;
                r.code = RC_ACC;
            end
            OP_STOP: begin
                stopped = 1;
                r.code = RC_STOP;
            end
            default: r.code = RC_NONE;
        endcase
        for (int i = 0; i < n; i++)
            if (slot_st[i] == SL_BUSY) busy++;
        r.done = done_cnt;
        r.busy = busy[6:0];
        r.rnd = cur_round;
        r.alld = (longint'(done_cnt) >= chunk_total());
        return r;
    endfunction

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result receiver with random back-pressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        end
    endtask

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_dispatch_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual code %0h",
                         $time, o_result_code);
            end else begin
                e = pending_results.pop_front();
                check_field("result_code", e.code, o_result_code);
                check_field("granted_chunk", e.chunk, o_granted_chunk);
                check_field("first_block", e.first, o_first_block);
                check_field("last_block", e.last, o_last_block);
                check_field("completed_total", e.done, o_completed_total);
                check_field("busy_slots", e.busy, o_busy_slots);
                check_field("round_number", e.rnd, o_round_number);
                check_field("all_done", e.alld, o_all_done);
            end
        end
    end

    // Present one request and hold it until accepted; typed rows override the mirror.
    task automatic send_request(logic [2:0] op, logic [31:0] id, bit typed = 0,
                                t_dispatch_result given = '{default: '0});
        t_dispatch_result r;
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_chunk_number <= id;
        in_hi = 1;
        do @(posedge i_clk); while (!o_in_ready);
        r = dispatch_outcome(op, id);
        pending_results.push_back(typed ? given : r);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            in_hi = 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        if (in_hi) begin
            @(posedge i_clk);
            i_in_valid <= 1'b0;
            in_hi = 0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all five registers one after another while the block is idle.
    task automatic load_config(logic [31:0] st, logic [31:0] en, logic [31:0] ch,
                               logic [31:0] sl, logic [31:0] to);
        logic [31:0] vals[5];
        logic [2:0]  idx[5];
        vals = '{st, en, ch, sl, to};
        idx = '{CFG_START, CFG_END, CFG_CHUNK, CFG_SLOTS, CFG_TIMEOUT};
        wait_idle();
        for (int k = 0; k < 5; k++) begin
            @(posedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_START:   cfg_start = vals[k];
                CFG_END:     cfg_end = vals[k];
                CFG_CHUNK:   cfg_chunk = vals[k][15:0];
                CFG_SLOTS:   cfg_slots = vals[k][6:0];
                CFG_TIMEOUT: cfg_timeout = vals[k][15:0];
                default: ;
            endcase
            i_cfg_valid <= 1'b0;
        end
    endtask

    // Random requests: mostly claims and completes of the current round.
    task automatic random_requests(int count, bit mid_pause);
        int unsigned pick, n;
        logic [2:0] op;
        logic [31:0] id;
        for (int k = 0; k < count; k++) begin
            n = slots_n();
            pick = $urandom_range(99);
            id = $urandom;
            if (pick < 35) begin
                op = OP_CLAIM;
            end else if (pick < 65) begin
                op = OP_COMPLETE;
                if ($urandom_range(9) < 8) id = cur_round * n + $urandom_range(n - 1);
            end else if (pick < 75) begin
                op = OP_FAIL;
                if ($urandom_range(9) < 7) id = cur_round * n + $urandom_range(n - 1);
            end else if (pick < 84) begin
                op = OP_CHECK;
            end else if (pick < 97) begin
                op = OP_TICK;
            end else begin
                op = $urandom_range(6, 7);
            end
            send_request(op, id);
            if (mid_pause && k == count / 2) wait_idle();
        end
    endtask

    function automatic t_dispatch_result res(logic [2:0] code, logic [31:0] chunk,
                                             logic [31:0] done, logic [6:0] busy,
                                             logic alld);
        return '{code, chunk, 32'd0, 32'd0, done, busy, 32'd0, alld};
    endfunction

    // Directed requests under the reset configuration (one slot, one block).
    t_request_row reset_rows[] = '{
        '{OP_CLAIM,    32'd0,          1, res(RC_GRANT, 0, 0, 1, 0)},
        '{OP_FAIL,     32'd0,          1, res(RC_ACC,   0, 0, 0, 0)},
        '{OP_CLAIM,    32'd0,          1, res(RC_GRANT, 0, 0, 1, 0)},
        '{OP_TICK,     32'd0,          1, res(RC_ACC,   0, 0, 1, 0)},
        '{OP_CHECK,    32'd0,          1, res(RC_ACC,   0, 0, 0, 0)},
        '{OP_CLAIM,    32'd0,          0, '{default: '0}},
        '{OP_COMPLETE, 32'd0,          1, res(RC_ACC,   0, 1, 0, 1)},
        '{OP_CLAIM,    32'hFFFF_FFFF,  1, res(RC_NONE,  0, 1, 0, 1)},
        '{OP_COMPLETE, 32'hFFFF_FFFF,  1, res(RC_STALE, 0, 1, 0, 1)},
        '{OP_FAIL,     32'd1,          1, res(RC_STALE, 0, 1, 0, 1)},
        '{3'd6,        32'd0,          1, res(RC_NONE,  0, 1, 0, 1)},
        '{3'd7,        32'hAAAA_5555,  1, res(RC_NONE,  0, 1, 0, 1)},
        '{OP_COMPLETE, 32'd0,          1, res(RC_ACC,   0, 2, 0, 1)},
        '{OP_FAIL,     32'd0,          0, '{default: '0}},
        '{OP_CHECK,    32'd0,          0, '{default: '0}}
    };

    // Main sequence.
    initial begin
        logic [31:0] st;
        for (int i = 0; i < NSLOT; i++) begin
            slot_st[i] = SL_FREE;
            slot_ts[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (reset_rows[k])
            send_request(reset_rows[k].op, reset_rows[k].id, reset_rows[k].typed,
                         reset_rows[k].res);

        // Fixed settings, extremes among them.
        load_config(100, 1099, 10, 8, 0);
        random_requests(200, 1);
        idle_pct = 0;
        load_config(0, 32'hFFFF_FFFF, 32'hFFFF_0000, 64, 65535);
        random_requests(200, 0);
        idle_pct = 13;
        load_config(32'hFFFF_FF00, 32'hFFFF_FFFF, 65535, 32'hFFFF_FF80, 1);
        random_requests(120, 0);
        load_config(50, 10, 3, 100, 0);
        random_requests(80, 0);
        load_config(0, 99, 7, 4, 0);
        random_requests(200, 0);
        load_config(32'hFFFF_FFF0, 32'hFFFF_FFFF, 3, 127, 2);
        random_requests(120, 0);
        load_config(0, 0, 0, 1, 0);
        random_requests(80, 0);

        // Random settings with small ranges so rounds keep advancing.
        for (int p = 0; p < 6; p++) begin
            st = $urandom;
            load_config(st, st + $urandom_range(0, 3000), $urandom_range(0, 300)
                        | ($urandom << 16), $urandom_range(0, 127) | ($urandom << 7),
                        $urandom_range(0, 3) | ($urandom << 16));
            random_requests(130, 0);
        end

        // Stop, then random requests and a second stop.
        load_config(0, 200, 5, 6, 0);
        random_requests(40, 0);
        send_request(OP_STOP, $urandom);
        random_requests(30, 0);
        send_request(OP_STOP, $urandom);

        wait_idle();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
